// File: rtl/audio_shift_saturate_pingpong_defines.svh
// Assertion macros shared by the audio shift/saturate ping-pong RTL.
// Depends on nothing; files that check their logic include it.
`ifndef AUDIO_SHIFT_SATURATE_PINGPONG_DEFINES_SVH
`define AUDIO_SHIFT_SATURATE_PINGPONG_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, off while reset is held.
`define ASP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also during reset.
`define ASP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASP_ASSERT(lbl, prop, msg)
`define ASP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/asp_pkg.sv
// Package for the audio shift/saturate ping-pong block: constants, types, helpers.
// No dependencies; the other .sv RTL files refer into it by scoped names.
package asp_pkg;

  // Sample format and buffer sizing
  localparam int SAMPLE_BITS   = 24;
  localparam int WAV_BUF_MAX   = 4096;
  localparam int INFER_BUF_MAX = 4096;
  localparam int BUF_MAX_ALL   = (WAV_BUF_MAX > INFER_BUF_MAX) ? WAV_BUF_MAX : INFER_BUF_MAX;
  localparam int CNT_W         = $clog2(BUF_MAX_ALL);
  localparam int LEN_EFF_W     = CNT_W + 1;

  // Fixed port widths
  localparam int RAW_W   = 32;
  localparam int SAMP_W  = 16;
  localparam int VOL_W   = 4;
  localparam int LEN_W   = 13;
  localparam int INDEX_W = 12;
  localparam int RATE_W  = 8;
  localparam int CFG_IDX_W = 3;

  // Shift/saturate datapath
  localparam int WIDE_W    = 48;
  localparam int BASE_SH   = 32 - SAMPLE_BITS;
  localparam int VOL_MIN   = -2;
  localparam int VOL_MAX   = 4;
  localparam int RSH_MAX   = WIDE_W - 1;
  localparam int LSH_MAX   = WIDE_W - RAW_W - 1;
  localparam int SAT_MAX   = 32767;
  localparam int SAT_MIN   = -32768;

  // Register reset values
  localparam logic [LEN_W-1:0]  BUF_LEN_RST   = LEN_W'(4096);
  localparam logic [RATE_W-1:0] SKIP_RATE_RST = RATE_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_SHIFT       = 3'd0,
    CFG_WAV_ENABLE       = 3'd1,
    CFG_WAV_BUFFER_LEN   = 3'd2,
    CFG_INFER_ENABLE     = 3'd3,
    CFG_INFER_BUFFER_LEN = 3'd4,
    CFG_SKIP_RATE        = 3'd5
  } cfg_idx_t;

  // Per-beat control into one ping-pong address generator
  typedef struct packed {
    logic en;        // path enabled
    logic keep;      // sample kept for this path
    logic consumed;  // consumer cleared ready before this sample
    logic active;    // consumer running, overrun detection on
  } path_ctl_t;

  // Per-beat result of one ping-pong address generator
  typedef struct packed {
    logic               write;
    logic               bank;
    logic [INDEX_W-1:0] index;
    logic               swap;
    logic               overrun;
  } path_res_t;

  // Bank length as used: zero acts as one, capped at the bank maximum
  function automatic logic [LEN_EFF_W-1:0] eff_len(input logic [LEN_W-1:0] len,
                                                   input int max_len);
    logic [31:0] l32;
    logic [31:0] r32;
    l32 = 32'(len);
    if (l32 == 32'd0) begin
      r32 = 32'd1;
    end else if (l32 > 32'(max_len)) begin
      r32 = 32'(max_len);
    end else begin
      r32 = l32;
    end
    return LEN_EFF_W'(r32);
  endfunction

endpackage

// File: rtl/audio_shift_saturate_pingpong.sv
// Top level: config registers, input/result registers, skip decimator and two paths.
// Depends on asp_pkg, asp_gain_sat, asp_pingpong and the assertion macro header.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | raw_word, wav/infer consumer flags
//  out_    | output    | out_valid / out_stall | sample, clip, wav/infer bank activity
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Beats pass the input, then the result register; one per cycle unless out_stall.
// The input register feeds shift, saturate and both bank counters, whose state
// updates as the beat moves into the result register.
// Synchronous active-low reset empties both registers and clears all state.
// in_stall rises only when the input register holds a beat the stalled result
// register cannot take; cfg_ready is always high.
`include "audio_shift_saturate_pingpong_defines.svh"
module audio_shift_saturate_pingpong (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [asp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [asp_pkg::LEN_W-1:0]              cfg_data,
  // input beats
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [asp_pkg::RAW_W-1:0]       in_raw_word,
  input  logic                                   in_wav_recording,
  input  logic                                   in_wav_consumed,
  input  logic                                   in_infer_running,
  input  logic                                   in_infer_consumed,
  // result beats
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [asp_pkg::SAMP_W-1:0]      out_sample_out,
  output logic                                   out_clipped,
  output logic                                   out_wav_write,
  output logic                                   out_wav_bank,
  output logic [asp_pkg::INDEX_W-1:0]            out_wav_index,
  output logic                                   out_wav_swap,
  output logic                                   out_wav_overrun,
  output logic                                   out_infer_write,
  output logic                                   out_infer_bank,
  output logic [asp_pkg::INDEX_W-1:0]            out_infer_index,
  output logic                                   out_infer_swap,
  output logic                                   out_infer_overrun
);

  // Configuration registers
  logic signed [asp_pkg::VOL_W-1:0] gain_shift_r;
  logic                             wav_enable_r;
  logic [asp_pkg::LEN_W-1:0]        wav_buffer_len_r;
  logic                             infer_enable_r;
  logic [asp_pkg::LEN_W-1:0]        infer_buffer_len_r;
  logic [asp_pkg::RATE_W-1:0]       skip_rate_r;

  // Input register
  logic                             s1_valid_r;
  logic signed [asp_pkg::RAW_W-1:0] s1_raw_r;
  logic                             s1_wav_rec_r;
  logic                             s1_wav_cons_r;
  logic                             s1_inf_run_r;
  logic                             s1_inf_cons_r;

  // Result register
  logic                              out_valid_r;
  logic signed [asp_pkg::SAMP_W-1:0] out_sample_r;
  logic                              out_clipped_r;
  asp_pkg::path_res_t                out_wav_r;
  asp_pkg::path_res_t                out_inf_r;

  // Decimator phase
  logic [asp_pkg::RATE_W-1:0] skip_phase_r, skip_phase_nxt;
  logic [asp_pkg::RATE_W-1:0] rate_eff;
  logic                       inf_keep;

  logic                              adv;
  logic                              in_take;
  logic signed [asp_pkg::SAMP_W-1:0] sample_c;
  logic                              clipped_c;
  asp_pkg::path_ctl_t                wav_ctl;
  asp_pkg::path_ctl_t                inf_ctl;
  asp_pkg::path_res_t                wav_res;
  asp_pkg::path_res_t                inf_res;
  logic [asp_pkg::LEN_EFF_W-1:0]     wav_len_eff;
  logic [asp_pkg::LEN_EFF_W-1:0]     inf_len_eff;

  // Handshake: beat moves on when the result register is empty or being taken
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_shift_r       <= '0;
      wav_enable_r       <= 1'b0;
      wav_buffer_len_r   <= asp_pkg::BUF_LEN_RST;
      infer_enable_r     <= 1'b0;
      infer_buffer_len_r <= asp_pkg::BUF_LEN_RST;
      skip_rate_r        <= asp_pkg::SKIP_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (asp_pkg::cfg_idx_t'(cfg_index))
        asp_pkg::CFG_GAIN_SHIFT:       gain_shift_r       <= cfg_data[asp_pkg::VOL_W-1:0];
        asp_pkg::CFG_WAV_ENABLE:       wav_enable_r       <= cfg_data[0];
        asp_pkg::CFG_WAV_BUFFER_LEN:   wav_buffer_len_r   <= cfg_data;
        asp_pkg::CFG_INFER_ENABLE:     infer_enable_r     <= cfg_data[0];
        asp_pkg::CFG_INFER_BUFFER_LEN: infer_buffer_len_r <= cfg_data;
        asp_pkg::CFG_SKIP_RATE:        skip_rate_r        <= cfg_data[asp_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_raw_r      <= in_raw_word;
      s1_wav_rec_r  <= in_wav_recording;
      s1_wav_cons_r <= in_wav_consumed;
      s1_inf_run_r  <= in_infer_running;
      s1_inf_cons_r <= in_infer_consumed;
    end
  end

  // Shift and saturate
  asp_gain_sat u_gain_sat (
    .raw_word   (s1_raw_r),
    .gain_shift (gain_shift_r),
    .sample     (sample_c),
    .clipped    (clipped_c)
  );

  // Inference decimator: keep when phase reaches the rate
  always_comb begin
    rate_eff       = (skip_rate_r == '0) ? asp_pkg::RATE_W'(1) : skip_rate_r;
    inf_keep       = (skip_phase_r >= rate_eff);
    skip_phase_nxt = skip_phase_r;
    if (infer_enable_r) begin
      skip_phase_nxt = inf_keep ? asp_pkg::RATE_W'(1) : skip_phase_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_phase_r <= asp_pkg::SKIP_RATE_RST;
    end else if (adv) begin
      skip_phase_r <= skip_phase_nxt;
    end
  end

  // Bank address generators
  assign wav_len_eff = asp_pkg::eff_len(wav_buffer_len_r, asp_pkg::WAV_BUF_MAX);
  assign inf_len_eff = asp_pkg::eff_len(infer_buffer_len_r, asp_pkg::INFER_BUF_MAX);

  assign wav_ctl = '{en: wav_enable_r, keep: 1'b1,
                     consumed: s1_wav_cons_r, active: s1_wav_rec_r};
  assign inf_ctl = '{en: infer_enable_r, keep: inf_keep,
                     consumed: s1_inf_cons_r, active: s1_inf_run_r};

  asp_pingpong u_wav_pp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl     (wav_ctl),
    .len_eff (wav_len_eff),
    .res     (wav_res)
  );

  asp_pingpong u_inf_pp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .ctl     (inf_ctl),
    .len_eff (inf_len_eff),
    .res     (inf_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r  <= sample_c;
      out_clipped_r <= clipped_c;
      out_wav_r     <= wav_res;
      out_inf_r     <= inf_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_clipped       = out_clipped_r;
  assign out_wav_write     = out_wav_r.write;
  assign out_wav_bank      = out_wav_r.bank;
  assign out_wav_index     = out_wav_r.index;
  assign out_wav_swap      = out_wav_r.swap;
  assign out_wav_overrun   = out_wav_r.overrun;
  assign out_infer_write   = out_inf_r.write;
  assign out_infer_bank    = out_inf_r.bank;
  assign out_infer_index   = out_inf_r.index;
  assign out_infer_swap    = out_inf_r.swap;
  assign out_infer_overrun = out_inf_r.overrun;

  `ASP_ASSERT_ALWAYS(a_stall_needs_beat, in_stall |-> s1_valid_r, "stall with empty input register")
  `ASP_ASSERT(a_phase_nonzero, skip_phase_r != '0, "skip phase reached zero")
  `ASP_ASSERT(a_adv_fills_out, adv |=> out_valid_r, "advanced beat lost")

endmodule

// File: rtl/asp_gain_sat.sv
// Gain shift and 16-bit saturation of one MSB-aligned microphone word.
// Depends on asp_pkg for widths and limits.
module asp_gain_sat (
  input  logic signed [asp_pkg::RAW_W-1:0]  raw_word,
  input  logic signed [asp_pkg::VOL_W-1:0]  gain_shift,
  output logic signed [asp_pkg::SAMP_W-1:0] sample,
  output logic                              clipped
);

  logic signed [asp_pkg::VOL_W-1:0]  vol_c;
  logic signed [7:0]                 tot_sh;
  logic        [7:0]                 rsh;
  logic        [7:0]                 lsh;
  logic signed [asp_pkg::WIDE_W-1:0] wide;
  logic signed [asp_pkg::WIDE_W-1:0] shifted;

  // Clamp volume, then form total shift (negative means shift left)
  always_comb begin
    if (gain_shift < asp_pkg::VOL_W'(asp_pkg::VOL_MIN)) begin
      vol_c = asp_pkg::VOL_W'(asp_pkg::VOL_MIN);
    end else if (gain_shift > asp_pkg::VOL_W'(asp_pkg::VOL_MAX)) begin
      vol_c = asp_pkg::VOL_W'(asp_pkg::VOL_MAX);
    end else begin
      vol_c = gain_shift;
    end
    tot_sh = 8'(asp_pkg::BASE_SH) - 8'(vol_c);
  end

  // Arithmetic shift in a wide signed domain
  always_comb begin
    wide = asp_pkg::WIDE_W'(raw_word);
    rsh  = 8'd0;
    lsh  = 8'd0;
    if (tot_sh >= 0) begin
      rsh = (tot_sh > 8'(asp_pkg::RSH_MAX)) ? 8'(asp_pkg::RSH_MAX) : tot_sh;
      shifted = wide >>> rsh[5:0];
    end else begin
      lsh = 8'(-tot_sh);
      if (lsh > 8'(asp_pkg::LSH_MAX)) begin
        lsh = 8'(asp_pkg::LSH_MAX);
      end
      shifted = wide <<< lsh[5:0];
    end
  end

  // Saturate to 16 bits
  always_comb begin
    clipped = 1'b0;
    sample  = shifted[asp_pkg::SAMP_W-1:0];
    if (shifted > asp_pkg::WIDE_W'(asp_pkg::SAT_MAX)) begin
      sample  = asp_pkg::SAMP_W'(asp_pkg::SAT_MAX);
      clipped = 1'b1;
    end else if (shifted < asp_pkg::WIDE_W'(asp_pkg::SAT_MIN)) begin
      sample  = asp_pkg::SAMP_W'(asp_pkg::SAT_MIN);
      clipped = 1'b1;
    end
  end

endmodule

// File: rtl/asp_pingpong.sv
// Ping-pong bank address generator: bank, write index, swap and overrun.
// Depends on asp_pkg (path_ctl_t, path_res_t) and the assertion macro header.
`include "audio_shift_saturate_pingpong_defines.svh"
module asp_pingpong (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  asp_pkg::path_ctl_t               ctl,
  input  logic [asp_pkg::LEN_EFF_W-1:0]    len_eff,
  output asp_pkg::path_res_t               res
);

  logic                         bank_r, bank_nxt;
  logic [asp_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic                         ready_r, ready_nxt;
  logic [asp_pkg::LEN_EFF_W-1:0] count_inc;
  logic                         ready_c;

  // Result of the beat in the input register and the state it leaves
  always_comb begin
    res       = '0;
    bank_nxt  = bank_r;
    count_nxt = count_r;
    ready_c   = ctl.consumed ? 1'b0 : ready_r;
    ready_nxt = ready_c;
    count_inc = asp_pkg::LEN_EFF_W'(count_r) + 1'b1;
    if (ctl.en && ctl.keep) begin
      res.write = 1'b1;
      res.bank  = bank_r;
      res.index = asp_pkg::INDEX_W'(count_r);
      if (count_inc >= len_eff) begin
        res.swap    = 1'b1;
        res.overrun = ctl.active && ready_c;
        bank_nxt    = ~bank_r;
        count_nxt   = '0;
        ready_nxt   = 1'b1;
      end else begin
        count_nxt = count_inc[asp_pkg::CNT_W-1:0];
      end
    end
  end

  // State registers, updated when the beat moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      count_r <= '0;
      ready_r <= 1'b0;
    end else if (adv) begin
      bank_r  <= bank_nxt;
      count_r <= count_nxt;
      ready_r <= ready_nxt;
    end
  end

  `ASP_ASSERT(a_swap_sets_ready, adv && res.swap |=> ready_r, "ready not set after swap")
  `ASP_ASSERT(a_overrun_on_swap, res.overrun |-> res.swap && ready_c, "overrun without swap")
  `ASP_ASSERT(a_idle_holds, adv && !(ctl.en && ctl.keep) |=> $stable(count_r) && $stable(bank_r), "counter moved without write")

endmodule
